// ===== src/llt_pkg.sv =====
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types and constants of the level list tree linker: item structs,
// status and kind codes, register indexes and the stack entry layout.
// ----------------------------------------------------------------------------
package llt_pkg;

	// Default sizes
	localparam int STACK_LEVELS_DEF = 32;
	localparam int NODE_CAP_DEF     = 65536;

	// Work accounting
	localparam int          RECORD_BYTES = 32;
	localparam logic [31:0] NODE_COST    = 32'(RECORD_BYTES + 1);

	// Sibling code for a first child
	localparam logic [16:0] NONE_SIB = 17'h10000;

	// Request codes
	localparam logic REQ_NODE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEPTH_LIMIT = 2'd0,
		REG_WORK_BUDGET = 2'd1
	} reg_index_t;

	localparam logic [4:0]  DEPTH_LIMIT_RST = 5'd31;
	localparam logic [31:0] WORK_BUDGET_RST = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_DEPTH     = 3'd2,
		ST_WORK      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_LINK  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] node_index;
		logic [15:0] parent_index;
		logic [16:0] prev_sibling;
		logic [16:0] span_end;
		logic [15:0] child_total;
		logic [4:0]  deepest_level;
		logic [2:0]  status;
		logic        last;
	} out_item_t;

	// One stack level: ancestor ordinal, last child so far, child count
	typedef struct packed {
		logic [15:0] anc;
		logic [16:0] last_kid;
		logic [15:0] child_cnt;
	} stk_entry_t;

	// Admission decision for an accepted item
	typedef struct packed {
		logic        fail;
		status_t     code;
		logic [15:0] fail_node;
		logic        is_end;
	} adm_t;

endpackage

// ===== src/llt_ram.sv =====
// ----------------------------------------------------------------------------
// llt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module llt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, and register the read word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/llt_cfg.sv =====
// ----------------------------------------------------------------------------
// llt_cfg
// Configuration registers: depth limit and work budget, written through
// their own valid/ready channel.
// ----------------------------------------------------------------------------
module llt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [llt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [llt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [4:0]                     depth_limit,
	output logic [31:0]                    work_budget
);
	import llt_pkg::*;

	logic [4:0]  depth_limit_q;
	logic [31:0] work_budget_q;

	assign cfg_ready   = 1'b1;
	assign depth_limit = depth_limit_q;
	assign work_budget = work_budget_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= DEPTH_LIMIT_RST;
			work_budget_q <= WORK_BUDGET_RST;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_DEPTH_LIMIT: depth_limit_q <= cfg_data[4:0];
				REG_WORK_BUDGET: work_budget_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/llt_admit.sv =====
// ----------------------------------------------------------------------------
// llt_admit
// Checks an incoming item against the tree state: sticky error, empty tree,
// node overflow, work budget, malformed level and depth limit, in that order.
// ----------------------------------------------------------------------------
module llt_admit #(
	parameter int STACK_LEVELS = llt_pkg::STACK_LEVELS_DEF,
	parameter int NODE_CAP     = llt_pkg::NODE_CAP_DEF
) (
	input  llt_pkg::in_item_t                      item,
	input  llt_pkg::status_t                       err_status,
	input  logic [15:0]                            err_node,
	input  logic [$clog2(NODE_CAP+1)-1:0]          node_cnt,
	input  logic [$clog2(STACK_LEVELS+1)-1:0]      open_cnt,
	input  logic [31:0]                            spent,
	input  logic [31:0]                            budget,
	input  logic [4:0]                             depth_limit,
	output llt_pkg::adm_t                          adm
);
	import llt_pkg::*;

	localparam int NCW  = $clog2(NODE_CAP + 1);
	localparam int OCW  = $clog2(STACK_LEVELS + 1);
	localparam int CMPW = OCW + 8;

	logic [NCW+15:0] ord_wide;
	logic [CMPW-1:0] lvl_c;
	logic [CMPW-1:0] open_c;
	logic [31:0]     left;
	logic            first;
	logic            malformed;
	logic            too_deep;

	assign ord_wide  = {16'd0, node_cnt};
	assign lvl_c     = CMPW'(item.level);
	assign open_c    = CMPW'(open_cnt);
	assign left      = (spent > budget) ? 32'd0 : budget - spent;
	assign first     = (node_cnt == '0);
	assign malformed = first ? (item.level != 8'd0)
	                         : ((item.level == 8'd0) || (lvl_c > open_c));
	assign too_deep  = (item.level > {3'd0, depth_limit}) ||
	                   (lvl_c >= CMPW'(STACK_LEVELS));

	// Pick the first failing check
	always_comb begin
		adm           = '0;
		adm.code      = ST_OK;
		adm.is_end    = (item.req_type == REQ_END);
		adm.fail_node = ord_wide[15:0];
		if (err_status != ST_OK) begin
			adm.fail      = 1'b1;
			adm.code      = err_status;
			adm.fail_node = err_node;
		end else if (item.req_type == REQ_END) begin
			if (first) begin
				adm.fail      = 1'b1;
				adm.code      = ST_EMPTY;
				adm.fail_node = 16'd0;
			end
		end else if (node_cnt == NCW'(NODE_CAP)) begin
			adm.fail = 1'b1;
			adm.code = ST_MALFORMED;
		end else if (left < NODE_COST) begin
			adm.fail = 1'b1;
			adm.code = ST_WORK;
		end else if (malformed) begin
			adm.fail = 1'b1;
			adm.code = ST_MALFORMED;
		end else if (too_deep) begin
			adm.fail = 1'b1;
			adm.code = ST_DEPTH;
		end
	end

endmodule

// ===== src/level_list_tree_linker.sv =====
// ----------------------------------------------------------------------------
// level_list_tree_linker
// Rebuilds parent and sibling links from a preorder stream of node levels
// with an ancestor stack held in one RAM; the top of stack lives in flops.
// ----------------------------------------------------------------------------
// Flow: an accepted item enters the busy state, which registers a result for
//   each subtree close, then a node's link, or a single error, and holds while
//   the output stalls; busy blocks new items. A close reads stack RAM at most once.
// Reset: control state, counters and sticky error clear at once; config
//   registers take their defaults. The stack RAM has no clearing pass.
// ----------------------------------------------------------------------------
module level_list_tree_linker #(
	parameter int STACK_LEVELS = llt_pkg::STACK_LEVELS_DEF,
	parameter int NODE_CAP     = llt_pkg::NODE_CAP_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  llt_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output llt_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [llt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [llt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import llt_pkg::*;

	localparam int NCW = $clog2(NODE_CAP + 1);
	localparam int OCW = $clog2(STACK_LEVELS + 1);
	localparam int IW  = $clog2(STACK_LEVELS);
	localparam int EW  = $bits(stk_entry_t);

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	state_t            state_q;
	logic [OCW-1:0]    open_q;
	logic [NCW-1:0]    node_cnt_q;
	logic [31:0]       spent_q;
	logic [4:0]        max_q;
	status_t           error_status_q;
	logic [15:0]       err_node_q;
	logic              err_pend_q;
	logic              is_end_q;
	logic [7:0]        level_q;
	logic [OCW-1:0]    keep_q;
	stk_entry_t        top_q;
	logic              rd_pend_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [4:0]        depth_limit;
	logic [31:0]       work_budget;
	adm_t              adm;

	logic              in_fire;
	logic              out_free;
	logic              act;
	logic              pop_case;
	logic              pop_fail;
	logic              do_close;
	logic              do_link;
	logic              finish_end;
	stk_entry_t        cur_top;
	stk_entry_t        rd_entry;
	logic [EW-1:0]     rd_word;
	logic              rd_en;
	logic [OCW-1:0]    rd_open;
	logic [IW-1:0]     rd_addr;
	logic              wr_en;
	logic [7:0]        wr_lvl;
	logic [IW-1:0]     wr_addr;
	stk_entry_t        wr_entry;
	logic [NCW+16:0]   ord_wide;
	logic [16:0]       ord17;
	logic [4:0]        new_max;
	logic              emit;
	out_item_t         emit_item;

	llt_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.depth_limit (depth_limit),
		.work_budget (work_budget)
	);

	llt_admit #(
		.STACK_LEVELS (STACK_LEVELS),
		.NODE_CAP     (NODE_CAP)
	) u_admit (
		.item        (in_item),
		.err_status  (error_status_q),
		.err_node    (err_node_q),
		.node_cnt    (node_cnt_q),
		.open_cnt    (open_q),
		.spent       (spent_q),
		.budget      (work_budget),
		.depth_limit (depth_limit),
		.adm         (adm)
	);

	// Entries below the top are written when a child is pushed over them and
	// read only on a later pop, so read and write never hit one entry at once.
	llt_ram #(
		.WIDTH (EW),
		.DEPTH (STACK_LEVELS)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	assign rd_entry  = stk_entry_t'(rd_word);
	assign cur_top   = rd_pend_q ? rd_entry : top_q;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign ord_wide  = {17'd0, node_cnt_q};
	assign ord17     = ord_wide[16:0];
	assign new_max   = (level_q[4:0] > max_q) ? level_q[4:0] : max_q;

	// Decide this cycle's step
	assign act        = (state_q == S_BUSY) && out_free;
	assign pop_case   = act && !err_pend_q && (open_q > keep_q);
	assign pop_fail   = pop_case && (spent_q >= work_budget);
	assign do_close   = pop_case && !pop_fail;
	assign do_link    = act && !err_pend_q && !(open_q > keep_q);
	assign finish_end = do_close && is_end_q && (open_q == OCW'(1));

	// Fetch the next top while popping
	assign rd_open = open_q - OCW'(2);
	assign rd_addr = rd_open[IW-1:0];
	assign rd_en   = do_close && (open_q > OCW'(1));

	// Write the updated parent back when a child is pushed over it
	assign wr_lvl             = level_q - 8'd1;
	assign wr_addr            = wr_lvl[IW-1:0];
	assign wr_en              = do_link && (level_q != 8'd0);
	assign wr_entry.anc       = cur_top.anc;
	assign wr_entry.last_kid  = ord17;
	assign wr_entry.child_cnt = cur_top.child_cnt + 16'd1;

	// Build the result of this step
	always_comb begin
		emit                    = act;
		emit_item               = '0;
		emit_item.deepest_level = max_q;
		if (err_pend_q) begin
			emit_item.kind       = KIND_ERROR;
			emit_item.node_index = err_node_q;
			emit_item.status     = error_status_q;
			emit_item.last       = 1'b1;
		end else if (pop_fail) begin
			emit_item.kind       = KIND_ERROR;
			emit_item.node_index = cur_top.anc;
			emit_item.status     = ST_WORK;
			emit_item.last       = 1'b1;
		end else if (pop_case) begin
			emit_item.kind        = KIND_CLOSE;
			emit_item.node_index  = cur_top.anc;
			emit_item.span_end    = ord17;
			emit_item.child_total = cur_top.child_cnt;
			emit_item.status      = ST_OK;
			emit_item.last        = finish_end;
		end else begin
			emit_item.kind          = KIND_LINK;
			emit_item.node_index    = ord17[15:0];
			emit_item.parent_index  = (level_q == 8'd0) ? 16'd0 : cur_top.anc;
			emit_item.prev_sibling  = (level_q == 8'd0) ? NONE_SIB : cur_top.last_kid;
			emit_item.deepest_level = new_max;
			emit_item.status        = ST_OK;
			emit_item.last          = 1'b1;
		end
	end

	// Sequencer, tree state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			open_q         <= '0;
			node_cnt_q     <= '0;
			spent_q        <= '0;
			max_q          <= '0;
			error_status_q <= ST_OK;
			err_node_q     <= '0;
			err_pend_q     <= 1'b0;
			is_end_q       <= 1'b0;
			level_q        <= '0;
			keep_q         <= '0;
			top_q          <= '0;
			rd_pend_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			// Load a new result, or drain the output register
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= emit_item;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q    <= S_BUSY;
						is_end_q   <= adm.is_end;
						level_q    <= in_item.level;
						keep_q     <= adm.is_end ? '0 : OCW'(in_item.level);
						err_pend_q <= adm.fail;
						if (adm.fail) begin
							error_status_q <= adm.code;
							err_node_q     <= adm.fail_node;
						end else if (!adm.is_end) begin
							spent_q <= spent_q + NODE_COST;
						end
					end
				end
				S_BUSY: begin
					if (act) begin
						if (err_pend_q) begin
							err_pend_q <= 1'b0;
							state_q    <= S_IDLE;
						end else if (pop_fail) begin
							error_status_q <= ST_WORK;
							err_node_q     <= cur_top.anc;
							state_q        <= S_IDLE;
						end else if (finish_end) begin
							// Tree done: start over for the next one
							open_q     <= '0;
							node_cnt_q <= '0;
							spent_q    <= '0;
							max_q      <= '0;
							rd_pend_q  <= 1'b0;
							state_q    <= S_IDLE;
						end else if (do_close) begin
							open_q    <= open_q - OCW'(1);
							spent_q   <= spent_q + 32'd1;
							rd_pend_q <= rd_en;
						end else begin
							top_q.anc       <= ord17[15:0];
							top_q.last_kid  <= NONE_SIB;
							top_q.child_cnt <= 16'd0;
							rd_pend_q       <= 1'b0;
							open_q          <= OCW'(level_q) + OCW'(1);
							max_q           <= new_max;
							node_cnt_q      <= node_cnt_q + NCW'(1);
							state_q         <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/level_list_tree_linker_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_list_tree_linker_chk
// Watches the item, result and register channels of the tree linker, keeps
// its own copy of the ancestor stacks and counters, and compares every result
// item in order against the links, closes and errors it predicts.
// ----------------------------------------------------------------------------
module level_list_tree_linker_chk
	import llt_pkg::*;
#(
	parameter int STACK_LEVELS = STACK_LEVELS_DEF,
	parameter int NODE_CAP     = NODE_CAP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  in_item_t               in_item,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  out_item_t              out_item,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending
);

	// Shadow ancestor stacks
	logic [15:0] anc_mem  [STACK_LEVELS];
	logic [16:0] sib_mem  [STACK_LEVELS];
	logic [15:0] kids_mem [STACK_LEVELS];

	// Tree state and sticky error
	int unsigned open_n;
	int unsigned node_n;
	logic [31:0] spent;
	logic [4:0]  deepest;
	status_t     err_code;
	logic [15:0] err_node;

	// Register copies
	logic [4:0]  lim;
	logic [31:0] budget;

	out_item_t awaited_items[$];
	int        mismatch_n;

	function automatic out_item_t make_item(kind_t k, logic [15:0] node, logic [15:0] parent,
			logic [16:0] sib, logic [16:0] sub_end, logic [15:0] kids, status_t st,
			logic lst);
		out_item_t r;
		r.kind          = k;
		r.node_index    = node;
		r.parent_index  = parent;
		r.prev_sibling  = sib;
		r.span_end      = sub_end;
		r.child_total   = kids;
		r.deepest_level = deepest;
		r.status        = st;
		r.last          = lst;
		return r;
	endfunction

	function automatic string fmt_item(out_item_t r);
		return {$sformatf("kind %0d node %0d parent %0d sib %0d end %0d ",
				r.kind, r.node_index, r.parent_index, r.prev_sibling, r.span_end),
			$sformatf("kids %0d deep %0d st %0d last %0d",
				r.child_total, r.deepest_level, r.status, r.last)};
	endfunction

	// Latch the error and emit its single result item
	task automatic raise_error(status_t code, logic [15:0] node);
		err_code = code;
		err_node = node;
		awaited_items.push_back(make_item(KIND_ERROR, node, '0, '0, '0, '0, code, 1'b1));
	endtask

	// Charge work units; a lowered budget below what is spent leaves nothing
	function automatic bit take_work(logic [31:0] amount);
		logic [31:0] left;
		left = (spent > budget) ? '0 : budget - spent;
		if (amount > left)
			return 1'b0;
		spent = spent + amount;
		return 1'b1;
	endfunction

	// Pop open subtrees down to keep levels, innermost first
	task automatic close_subtrees(input int unsigned keep, input int unsigned sub_end,
			input bit to_root, output bit ok);
		int unsigned top;
		ok = 1'b1;
		while (open_n > keep) begin
			top = (open_n - 1) % STACK_LEVELS;
			if (!take_work(32'd1)) begin
				raise_error(ST_WORK, anc_mem[top]);
				ok = 1'b0;
				return;
			end
			open_n--;
			awaited_items.push_back(make_item(KIND_CLOSE, anc_mem[top], '0, '0, 17'(sub_end),
				kids_mem[top], ST_OK, to_root && open_n == 0));
		end
	endtask

	// Work out the result items of one accepted item
	task automatic predict_tree_step(in_item_t it);
		int unsigned ord;
		int unsigned lv;
		int unsigned p;
		logic [15:0] parent;
		logic [16:0] sib;
		bit          ok;
		lv = it.level;
		if (err_code != ST_OK) begin
			raise_error(err_code, err_node);
			return;
		end
		if (it.req_type == REQ_END) begin
			if (node_n == 0) begin
				raise_error(ST_EMPTY, '0);
				return;
			end
			close_subtrees(0, node_n, 1'b1, ok);
			if (!ok)
				return;
			open_n  = 0;
			node_n  = 0;
			spent   = '0;
			deepest = '0;
			return;
		end
		ord = node_n;
		if (ord >= NODE_CAP) begin
			raise_error(ST_MALFORMED, 16'(ord));
			return;
		end
		if (!take_work(NODE_COST)) begin
			raise_error(ST_WORK, 16'(ord));
			return;
		end
		if ((ord == 0 && lv != 0) || (ord != 0 && (lv == 0 || lv > open_n))) begin
			raise_error(ST_MALFORMED, 16'(ord));
			return;
		end
		if (lv > lim || lv >= STACK_LEVELS) begin
			raise_error(ST_DEPTH, 16'(ord));
			return;
		end
		close_subtrees(lv, ord, 1'b0, ok);
		if (!ok)
			return;
		parent = '0;
		sib    = NONE_SIB;
		if (lv != 0) begin
			p           = (lv - 1) % STACK_LEVELS;
			parent      = anc_mem[p];
			sib         = sib_mem[p];
			kids_mem[p] = kids_mem[p] + 16'd1;
			sib_mem[p]  = 17'(ord);
		end
		anc_mem[lv % STACK_LEVELS]  = 16'(ord);
		sib_mem[lv % STACK_LEVELS]  = NONE_SIB;
		kids_mem[lv % STACK_LEVELS] = '0;
		open_n = lv + 1;
		if (lv > deepest)
			deepest = 5'(lv);
		node_n = ord + 1;
		awaited_items.push_back(make_item(KIND_LINK, 16'(ord), parent, sib, '0, '0, ST_OK, 1'b1));
	endtask

	// Compare one accepted result item with the oldest prediction
	task automatic check_result(out_item_t got);
		out_item_t want;
		if (awaited_items.size() == 0) begin
			mismatch_n++;
			if (mismatch_n <= 10)
				$display("[%0t] result with nothing awaited: %s", $time, fmt_item(got));
			return;
		end
		want = awaited_items.pop_front();
		if (got.kind !== want.kind || got.node_index !== want.node_index ||
				got.parent_index !== want.parent_index ||
				got.prev_sibling !== want.prev_sibling ||
				got.span_end !== want.span_end || got.child_total !== want.child_total ||
				got.deepest_level !== want.deepest_level || got.status !== want.status ||
				got.last !== want.last) begin
			mismatch_n++;
			if (mismatch_n <= 10) begin
				$display("[%0t] mismatch, expected: %s", $time, fmt_item(want));
				$display("[%0t] mismatch, actual:   %s", $time, fmt_item(got));
			end
		end
	endtask

	// Track registers, predict on accepted items, check accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_LEVELS; i++) begin
				anc_mem[i]  = '0;
				sib_mem[i]  = '0;
				kids_mem[i] = '0;
			end
			open_n     = 0;
			node_n     = 0;
			spent      = '0;
			deepest    = '0;
			err_code   = ST_OK;
			err_node   = '0;
			lim        = DEPTH_LIMIT_RST;
			budget     = WORK_BUDGET_RST;
			mismatch_n = 0;
			awaited_items.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEPTH_LIMIT: lim = cfg_data[4:0];
					REG_WORK_BUDGET: budget = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_tree_step(in_item);
			if (out_valid && out_ready)
				check_result(out_item);
			fail_count <= mismatch_n;
			pending    <= awaited_items.size();
		end
	end

endmodule

// ===== tb/sv/level_list_tree_linker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_list_tree_linker_tb
// Drives preorder level streams into the tree linker: a directed opening, then
// random well-formed trees under several register settings and idling modes,
// and finally one randomly chosen error case with sticky follow-up items.
// ----------------------------------------------------------------------------
module level_list_tree_linker_tb;
	import llt_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 54;
	localparam int MAX_TREE      = 40;

	// Indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	// Enough budget for the largest random tree
	localparam logic [31:0] TREE_BUDGET_MIN = 32'd1400;

	typedef enum int {
		ERR_FIRST_LEVEL,
		ERR_LEVEL_ZERO,
		ERR_LEVEL_JUMP,
		ERR_DEPTH,
		ERR_BUDGET,
		ERR_BUDGET_CUT,
		ERR_EMPTY
	} err_case_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_item   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_item;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int fail_count;
	int pending;
	int in_gap_pct    = 9;
	int out_stall_pct = 52;
	int depth_cap     = DEPTH_LIMIT_RST;
	int open_lv       = 0;
	int item_n        = 0;

	level_list_tree_linker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	level_list_tree_linker_chk link_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
	end

	// Offer one item, with random gaps before it, and hold until accepted
	task automatic send_item(input logic rq, input logic [7:0] lv);
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{req_type: rq, level: lv};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		item_n++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DEPTH_LIMIT)
			depth_cap = val[4:0];
		@(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has arrived
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Send a random preorder tree of up to n nodes within the depth limit
	task automatic send_tree(input int n, input bit chain, input bit close_tree);
		int         hi;
		logic [7:0] lv;
		open_lv = 0;
		for (int i = 0; i < n; i++) begin
			hi = (open_lv < depth_cap) ? open_lv : depth_cap;
			if (i != 0 && hi == 0)
				break;
			if (i == 0)
				lv = 8'd0;
			else if (chain || $urandom_range(0, 99) < 35)
				lv = 8'(hi);
			else if (open_lv >= 2 && $urandom_range(0, 99) < 50)
				lv = 8'(open_lv - 1);
			else
				lv = 8'($urandom_range(1, hi));
			send_item(REQ_NODE, lv);
			open_lv = lv + 1;
		end
		if (close_tree)
			send_item(REQ_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		err_case_t ec;
		int        n;
		int        r;
		int        phase_start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unmapped indexes must be ignored
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);

		// Directed: single node, nesting, siblings, wide sibling list
		send_item(REQ_NODE, 8'd0);
		send_item(REQ_END, 8'hFF);
		send_item(REQ_NODE, 8'd0);
		send_item(REQ_NODE, 8'd1);
		send_item(REQ_NODE, 8'd2);
		send_item(REQ_NODE, 8'd3);
		send_item(REQ_NODE, 8'd1);
		send_item(REQ_NODE, 8'd2);
		send_item(REQ_NODE, 8'd2);
		send_item(REQ_NODE, 8'd1);
		send_item(REQ_END, 8'h00);
		send_item(REQ_NODE, 8'd0);
		send_item(REQ_NODE, 8'd1);
		send_item(REQ_NODE, 8'd1);
		send_item(REQ_NODE, 8'd1);
		send_item(REQ_END, 8'h80);
		wait_idle();

		// Directed: lowest depth limit allows only a root
		write_reg(REG_DEPTH_LIMIT, 32'd0);
		send_item(REQ_NODE, 8'd0);
		send_item(REQ_END, 8'h7F);
		wait_idle();

		// Random trees under changing registers and idling modes
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph / 2)
				0: begin
					in_gap_pct    = 9;
					out_stall_pct = 52;
				end
				1: begin
					in_gap_pct    = 52;
					out_stall_pct = 9;
				end
				default: begin
					in_gap_pct    = 0;
					out_stall_pct = 0;
				end
			endcase
			case (ph)
				0: begin
					write_reg(REG_DEPTH_LIMIT, 32'(DEPTH_LIMIT_RST));
					write_reg(REG_WORK_BUDGET, WORK_BUDGET_RST);
				end
				1: begin
					write_reg(REG_DEPTH_LIMIT, 32'd0);
					write_reg(REG_WORK_BUDGET, $urandom_range(TREE_BUDGET_MIN, 32'hFFFF_FFFE));
				end
				2: begin
					write_reg(REG_DEPTH_LIMIT, $urandom_range(1, 30));
					write_reg(REG_WORK_BUDGET, WORK_BUDGET_RST);
				end
				3: begin
					write_reg(REG_DEPTH_LIMIT, 32'(DEPTH_LIMIT_RST));
					write_reg(REG_WORK_BUDGET, $urandom_range(TREE_BUDGET_MIN, 32'd5000));
				end
				4: begin
					write_reg(REG_DEPTH_LIMIT, $urandom_range(0, 31));
					write_reg(REG_WORK_BUDGET, WORK_BUDGET_RST);
				end
				default: begin
					write_reg(REG_DEPTH_LIMIT, 32'(DEPTH_LIMIT_RST));
					write_reg(REG_WORK_BUDGET, TREE_BUDGET_MIN);
				end
			endcase
			phase_start = item_n;
			while (item_n - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					send_tree(33, 1'b1, 1'b1);
				else if (r < 20)
					send_tree($urandom_range(20, MAX_TREE), 1'b0, 1'b1);
				else
					send_tree($urandom_range(1, 10), 1'b0, 1'b1);
			end
			wait_idle();
		end

		// One error case, then items that must repeat the sticky error
		write_reg(REG_WORK_BUDGET, WORK_BUDGET_RST);
		write_reg(REG_DEPTH_LIMIT, 32'(DEPTH_LIMIT_RST));
		ec = err_case_t'($urandom_range(0, ERR_EMPTY));
		case (ec)
			ERR_FIRST_LEVEL: send_item(REQ_NODE, 8'($urandom_range(1, 255)));
			ERR_LEVEL_ZERO: begin
				send_tree($urandom_range(1, 6), 1'b0, 1'b0);
				send_item(REQ_NODE, 8'd0);
			end
			ERR_LEVEL_JUMP: begin
				send_tree($urandom_range(1, 6), 1'b0, 1'b0);
				send_item(REQ_NODE, 8'($urandom_range(open_lv + 1, 255)));
			end
			ERR_DEPTH: begin
				n = $urandom_range(0, 31);
				write_reg(REG_DEPTH_LIMIT, 32'(n));
				send_tree(n + 1, 1'b1, 1'b0);
				send_item(REQ_NODE, 8'(n + 1));
			end
			ERR_BUDGET: begin
				write_reg(REG_WORK_BUDGET, $urandom_range(0, 300));
				send_tree(20, 1'b0, 1'b1);
			end
			ERR_BUDGET_CUT: begin
				send_tree($urandom_range(2, 8), 1'b0, 1'b0);
				wait_idle();
				write_reg(REG_WORK_BUDGET, $urandom_range(0, 264));
				repeat (20) send_item(REQ_NODE, 8'd1);
				send_item(REQ_END, 8'($urandom_range(0, 255)));
			end
			default: send_item(REQ_END, 8'($urandom_range(0, 255)));
		endcase
		repeat (4) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Give up on a hung run
	initial begin : watchdog
		#(CLK_PERIOD * 3_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
src/llt_pkg.sv
src/llt_ram.sv
src/llt_cfg.sv
src/llt_admit.sv
src/level_list_tree_linker.sv
tb/sv/level_list_tree_linker_chk.sv
tb/sv/level_list_tree_linker_tb.sv
